// File: rtl/rslh_pkg.sv
// ----------------------------------------------------------------------------
// rslh_pkg
// Shared constants, types and helper functions of the range scaled histogram.
// ----------------------------------------------------------------------------
package rslh_pkg;

    localparam int MAX_BUCKETS  = 256;
    localparam int SAMPLE_BITS  = 32;
    localparam int IDX_W        = $clog2(MAX_BUCKETS);
    localparam int NB_W         = 9;
    localparam int PROD_W       = 32 + NB_W;
    localparam int QUOT_W       = 22;
    localparam int STEP_W       = 6;
    localparam int LN_W         = 21;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BUCKETS    = 2'd2;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   num;
        logic [31:0]         den;
        logic [STEP_W-1:0]   steps;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } t_div_rsp;

    typedef struct packed {
        logic                done;
        logic [LN_W-1:0]     ln;
    } t_log_rsp;

    localparam logic [31:0] EXP_CEIL [22] = '{
        32'd3, 32'd8, 32'd21, 32'd55, 32'd149, 32'd404, 32'd1097, 32'd2981,
        32'd8104, 32'd22027, 32'd59875, 32'd162755, 32'd442414, 32'd1202605,
        32'd3269018, 32'd8886111, 32'd24154953, 32'd65659970, 32'd178482301,
        32'd485165196, 32'd1318815735, 32'd3584912847
    };

    // floor(ln(x)) by compare against rounded-up powers of e
    function automatic logic [4:0] floor_ln(input logic [31:0] x);
        logic [4:0] k;
        k = 5'd0;
        for (int i = 0; i < 22; i++) begin
            if (x >= EXP_CEIL[i]) k = 5'(i + 1);
        end
        return k;
    endfunction

endpackage

// File: rtl/rslh_div.sv
// ----------------------------------------------------------------------------
// rslh_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rslh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rslh_pkg::t_div_req i_req,
    output rslh_pkg::t_div_rsp o_rsp
);
    import rslh_pkg::*;

    logic                r_run, n_run;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_num, n_num;
    logic [31:0]         r_den, n_den;
    logic [31:0]         r_rem, n_rem;
    logic [QUOT_W-1:0]   r_q, n_q;
    logic [32:0]         trial;
    logic [STEP_W-1:0]   bit_pos;
    logic [PROD_W-1:0]   pre;

    assign bit_pos = r_cnt - STEP_W'(1);
    assign trial   = {r_rem, r_num[bit_pos]};
    assign pre     = i_req.num >> i_req.steps;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_req.start) begin
            // high part is known to be below the divisor
            n_run = 1'b1;
            n_cnt = i_req.steps;
            n_num = i_req.num;
            n_den = i_req.den;
            n_rem = pre[31:0];
            n_q   = '0;
        end else if (r_run) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = 32'(trial - {1'b0, r_den});
                n_q   = {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_q   = {r_q[QUOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// File: rtl/rslh_log.sv
// ----------------------------------------------------------------------------
// rslh_log
// Natural log in Q.16 by repeated squaring of the mantissa, one square a cycle.
// ----------------------------------------------------------------------------
module rslh_log (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_x,
    output rslh_pkg::t_log_rsp o_rsp
);
    import rslh_pkg::*;

    logic              r_run, n_run;
    logic              r_mul, n_mul;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [31:0]       r_m, n_m;
    logic [LN_W-1:0]   r_l2, n_l2;
    logic [LN_W-1:0]   r_ln, n_ln;
    logic [4:0]        msb;
    logic [63:0]       sq;
    logic [32:0]       sq_t;
    logic [LN_W+31:0]  prod;

    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) msb = 5'(i);
        end
    end

    assign sq   = r_m * r_m;
    assign sq_t = sq[63:31];
    assign prod = r_l2 * LN2_Q32;

    always_comb begin
        n_run  = r_run;
        n_mul  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_m    = r_m;
        n_l2   = r_l2;
        n_ln   = r_ln;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = 5'd16;
            n_m   = 32'(i_x << (5'd31 - msb));
            n_l2  = {msb, 16'd0};
        end else if (r_run) begin
            // square reached 2.0: halve and set this fraction bit
            if (sq_t[32]) begin
                n_m  = sq_t[32:1];
                n_l2 = r_l2 | (LN_W'(1) << (r_cnt - 5'd1));
            end else begin
                n_m  = sq_t[31:0];
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_run = 1'b0;
                n_mul = 1'b1;
            end
        end else if (r_mul) begin
            n_ln   = prod[LN_W+31:32];
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_mul  <= n_mul;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_m  <= n_m;
        r_l2 <= n_l2;
        r_ln <= n_ln;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ln   = r_ln;

endmodule

// File: rtl/range_scaled_log_histogram_top.sv
// ----------------------------------------------------------------------------
// range_scaled_log_histogram_top
// Intensity histogram with range binning and log level read-out.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. i_cmd selects
// add sample, read bucket or clear; code 3 is dropped.
// Add: bucket index from one 32x9 multiply and a 9 step pass of the shared
// divider, then a store read and write; a sample clamped to the first or
// last bucket skips the multiply and the divider.
// Read: store read, 16 squaring steps of the log unit, one multiply by ln2,
// then 22 steps of the same shared divider. A read of an empty bucket or
// with a peak below 3 skips the log unit and the divider and gives level
// zero.
// Clear: valid bits and peak drop at once.
// A read result is on o_valid and the o_ fields for exactly one cycle; the
// receiver cannot stall, and the next command may start in that cycle.
// Write registers on i_cfg_we only while the block is idle; it is not checked.
// Reset brings the registers to their defaults and empties the store.
// ----------------------------------------------------------------------------
module range_scaled_log_histogram_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_sample,
    input  logic [7:0]  i_read_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_bucket_echo,
    output logic [31:0] o_hit_total,
    output logic [15:0] o_log_level
);
    import rslh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_BDIV = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WT   = 3'd4;
    localparam logic [2:0] ST_LOG  = 3'd5;
    localparam logic [2:0] ST_LDIV = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [31:0]       r_low, r_high;
    logic [NB_W-1:0]   r_nb;
    logic [31:0]       r_peak, n_peak;
    logic              r_is_read, n_is_read;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [31:0]       r_diff, n_diff;
    logic [NB_W-1:0]   r_beff, n_beff;
    logic [4:0]        r_d, n_d;
    logic              r_valid, n_valid;
    logic [7:0]        r_echo, n_echo;
    logic [31:0]       r_hit, n_hit;
    logic [15:0]       r_lvl, n_lvl;

    logic [31:0]       r_mem [MAX_BUCKETS];
    logic              r_vld [MAX_BUCKETS];
    logic [31:0]       r_rd_data;
    logic              r_rd_vld;
    logic              mem_we;
    logic [31:0]       mem_wdata;
    logic              clr_all;

    logic [NB_W-1:0]   beff;
    logic [31:0]       cur;
    logic [31:0]       inc;
    logic [QUOT_W-1:0] lvl_q;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              log_start;
    t_log_rsp          log_rsp;

    rslh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rslh_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (cur),
        .o_rsp   (log_rsp)
    );

    always_comb begin
        if (r_nb == '0)                            beff = NB_W'(1);
        else if (r_nb > NB_W'(MAX_BUCKETS))        beff = NB_W'(MAX_BUCKETS);
        else                                       beff = r_nb;
    end

    assign cur   = r_rd_vld ? r_rd_data : 32'd0;
    assign inc   = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;
    assign lvl_q = div_rsp.quot;

    always_comb begin
        n_state   = r_state;
        n_peak    = r_peak;
        n_is_read = r_is_read;
        n_addr    = r_addr;
        n_diff    = r_diff;
        n_beff    = r_beff;
        n_d       = r_d;
        n_valid   = 1'b0;
        n_echo    = r_echo;
        n_hit     = r_hit;
        n_lvl     = r_lvl;
        mem_we    = 1'b0;
        mem_wdata = inc;
        clr_all   = 1'b0;
        log_start = 1'b0;
        div_req   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        CMD_ADD: begin
                            n_is_read = 1'b0;
                            n_beff    = beff;
                            n_diff    = i_sample - r_low;
                            if (r_high <= r_low || i_sample < r_low) begin
                                n_addr  = '0;
                                n_state = ST_RD;
                            end else if (i_sample >= r_high) begin
                                n_addr  = IDX_W'(beff - NB_W'(1));
                                n_state = ST_RD;
                            end else begin
                                n_state = ST_MUL;
                            end
                        end
                        CMD_READ: begin
                            n_is_read = 1'b1;
                            n_addr    = i_read_index;
                            n_d       = floor_ln(r_peak);
                            n_state   = ST_RD;
                        end
                        CMD_CLEAR: begin
                            clr_all = 1'b1;
                            n_peak  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_BDIV;
            end
            ST_BDIV: begin
                if (div_rsp.done) begin
                    if (lvl_q >= QUOT_W'(r_beff)) n_addr = IDX_W'(r_beff - NB_W'(1));
                    else                          n_addr = IDX_W'(lvl_q);
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WT;
            end
            ST_WT: begin
                if (!r_is_read) begin
                    mem_we  = 1'b1;
                    if (inc > r_peak) n_peak = inc;
                    n_state = ST_IDLE;
                end else begin
                    n_echo  = r_addr;
                    n_hit   = cur;
                    if (cur == 32'd0 || r_d == 5'd0) begin
                        n_lvl   = '0;
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_LOG;
                    end
                end
            end
            ST_LOG: begin
                if (log_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = PROD_W'(log_rsp.ln) + PROD_W'(r_d);
                    div_req.den   = {26'd0, r_d, 1'b0};
                    div_req.steps = STEP_W'(QUOT_W);
                    n_state       = ST_LDIV;
                end
            end
            ST_LDIV: begin
                if (div_rsp.done) begin
                    n_lvl   = (lvl_q > QUOT_W'(16'hFFFF)) ? 16'hFFFF : lvl_q[15:0];
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // bucket divide is launched as the product lands
        if (r_state == ST_MUL) begin
            div_req.start = 1'b1;
            div_req.num   = r_diff * r_beff;
            div_req.den   = r_high - r_low;
            div_req.steps = STEP_W'(NB_W);
        end
        // start the log unit as the count leaves the store
        if (r_state == ST_WT && r_is_read && cur != 32'd0 && r_d != 5'd0) begin
            log_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= 32'd0;
            r_high  <= 32'd255;
            r_nb    <= NB_W'(256);
            r_peak  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_LOW:  r_low  <= i_cfg_data;
                    REG_RANGE_HIGH: r_high <= i_cfg_data;
                    REG_BUCKETS:    r_nb   <= i_cfg_data[NB_W-1:0];
                    default: ;
                endcase
            end
        end
        r_is_read <= n_is_read;
        r_addr    <= n_addr;
        r_diff    <= n_diff;
        r_beff    <= n_beff;
        r_d       <= n_d;
        r_echo    <= n_echo;
        r_hit     <= n_hit;
        r_lvl     <= n_lvl;
    end

    // count store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= mem_wdata;
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int i = 0; i < MAX_BUCKETS; i++) r_vld[i] <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) r_vld[r_addr] <= 1'b1;
            r_rd_vld <= r_vld[r_addr];
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_bucket_echo = r_echo;
    assign o_hit_total   = r_hit;
    assign o_log_level   = r_lvl;

endmodule

// File: tb/tb_range_scaled_log_histogram_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_scaled_log_histogram_top
// Self-checking bench for the range scaled log histogram.
// ----------------------------------------------------------------------------
// A queue-fed driver sends add, read, clear and dropped commands with random
// gaps. A local model bins the samples, keeps counts and peak, and predicts
// each read beat. A monitor compares every read beat field by field. The
// bucket count and range registers are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_range_scaled_log_histogram_top;
    import rslh_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] sample;
        logic [7:0]  idx;
    } t_cmd_beat;

    typedef struct {
        logic [7:0]  bucket;
        logic [31:0] hits;
        logic [15:0] level;
    } t_read_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = CMD_ADD;
    logic [31:0] i_sample = '0;
    logic [7:0]  i_read_index = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_RANGE_LOW;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic [7:0]  o_bucket_echo;
    logic [31:0] o_hit_total;
    logic [15:0] o_log_level;

    range_scaled_log_histogram_top u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [31:0] lo_edge = 32'd0;
    logic [31:0] hi_edge = 32'd255;
    logic [8:0]  nbuckets = 9'd256;
    logic [31:0] hist [MAX_BUCKETS];
    logic [31:0] peak = '0;

    t_cmd_beat  pending [$];
    t_read_beat reads_due [$];
    t_cmd_beat  cur;
    bit         no_gaps = 0;
    int         errors = 0;
    int         beats_sent = 0;
    int         reads_seen = 0;
    int         cycles = 0;

    function automatic logic [4:0] ln_floor(logic [31:0] x);
        logic [4:0] k;
        k = '0;
        for (int i = 0; i < 22; i++)
            if (x >= EXP_CEIL[i]) k = 5'(i + 1);
        return k;
    endfunction

    // natural log in Q.16 via bitwise log2 and a multiply by ln2
    function automatic logic [63:0] ln_fixed(logic [31:0] x);
        int          n;
        logic [63:0] m;
        logic [63:0] l2;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0) n++;
        m = ({32'b0, x} << 31) >> n;
        l2 = 64'(n) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd2 << 31)) begin
                m = m >> 1;
                l2[i] = 1'b1;
            end
        end
        return (l2 * 64'(LN2_Q32)) >> 32;
    endfunction

    function automatic logic [15:0] level_for(logic [31:0] c);
        logic [63:0] d;
        logic [63:0] lv;
        d = 64'(ln_floor(peak));
        if (c == 0 || d == 0) return '0;
        lv = (ln_fixed(c) + d) / (2 * d);
        return lv > 65535 ? 16'hFFFF : lv[15:0];
    endfunction

    function automatic int bin_of(logic [31:0] v);
        logic [63:0] b;
        logic [63:0] q;
        b = 64'(nbuckets);
        if (b == 0) b = 1;
        if (b > MAX_BUCKETS) b = MAX_BUCKETS;
        if (hi_edge <= lo_edge || v < lo_edge) return 0;
        if (v >= hi_edge) return int'(b - 1);
        q = (64'(v - lo_edge) * b) / 64'(hi_edge - lo_edge);
        return q >= b ? int'(b - 1) : int'(q);
    endfunction

    task automatic apply_beat(t_cmd_beat c);
        int         b;
        t_read_beat r;
        case (c.cmd)
            CMD_ADD: begin
                b = bin_of(c.sample);
                if (hist[b] != 32'hFFFF_FFFF) hist[b]++;
                if (hist[b] > peak) peak = hist[b];
            end
            CMD_READ: begin
                r.bucket = c.idx;
                r.hits = hist[c.idx];
                r.level = level_for(r.hits);
                reads_due.push_back(r);
            end
            CMD_CLEAR: begin
                foreach (hist[i]) hist[i] = '0;
                peak = '0;
            end
            default: ;
        endcase
    endtask

    // driver: a beat is taken when start is high and busy is low
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                apply_beat(cur);
                beats_sent++;
            end
            if (!start || !busy) begin
                if (pending.size() > 0 && (no_gaps || $urandom_range(99) >= 6)) begin
                    cur = pending.pop_front();
                    start <= 1'b1;
                    i_cmd <= cur.cmd;
                    i_sample <= cur.sample;
                    i_read_index <= cur.idx;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_read_beat r;
        if (i_rst_n && o_valid) begin
            reads_seen++;
            if (reads_due.size() == 0) begin
                $display("%0t: read beat with none due: bucket %0d hits %0d level %0d",
                         $time, o_bucket_echo, o_hit_total, o_log_level);
                errors++;
            end else begin
                r = reads_due.pop_front();
                if (o_bucket_echo !== r.bucket) begin
                    $display("%0t: bucket_echo exp %0d got %0d", $time, r.bucket,
                             o_bucket_echo);
                    errors++;
                end
                if (o_hit_total !== r.hits) begin
                    $display("%0t: hit_total exp %0d got %0d", $time, r.hits,
                             o_hit_total);
                    errors++;
                end
                if (o_log_level !== r.level) begin
                    $display("%0t: log_level exp %0d got %0d", $time, r.level,
                             o_log_level);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push(logic [1:0] c, logic [31:0] s, logic [7:0] x);
        t_cmd_beat b;
        b.cmd = c;
        b.sample = s;
        b.idx = x;
        pending.push_back(b);
    endtask

    task automatic drain();
        wait (pending.size() == 0 && !start && reads_due.size() == 0);
        @(posedge i_clk);
        wait (!busy);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_RANGE_LOW:  lo_edge = val;
            REG_RANGE_HIGH: hi_edge = val;
            REG_BUCKETS:    nbuckets = val[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly samples spread around the range, some reads, rare clears and drops
    task automatic random_phase(int n);
        int          p;
        logic [31:0] s;
        logic [31:0] span;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 60) begin
                span = (hi_edge > lo_edge) ? hi_edge - lo_edge : 32'd16;
                case ($urandom_range(9))
                    0: s = $urandom();
                    1: s = lo_edge - 32'($urandom_range(3));
                    2: s = hi_edge + 32'($urandom_range(3));
                    3: s = lo_edge + 32'($urandom_range(7));
                    default: begin
                        // full span would wrap the modulus to zero
                        if (span == 32'hFFFF_FFFF) s = $urandom();
                        else s = lo_edge + ($urandom() % (span + 32'd1));
                    end
                endcase
                push(CMD_ADD, s, 8'($urandom()));
            end else if (p < 94) begin
                push(CMD_READ, $urandom(),
                     $urandom_range(1) ? 8'($urandom()) : 8'($urandom_range(7)));
            end else if (p < 97) begin
                push(2'd3, $urandom(), 8'($urandom()));
            end else begin
                push(CMD_CLEAR, $urandom(), 8'($urandom()));
            end
        end
    endtask

    initial begin
        foreach (hist[i]) hist[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, edges, empty reads, peak below and above 3
        push(CMD_READ, 32'hFFFF_FFFF, 8'd0);
        push(CMD_ADD, 32'd0, 8'hFF);
        push(CMD_READ, 32'd0, 8'd0);
        push(CMD_ADD, 32'd255, 8'd0);
        push(CMD_ADD, 32'hFFFF_FFFF, 8'd0);
        push(CMD_READ, 32'd0, 8'd255);
        push(CMD_ADD, 32'd128, 8'd0);
        push(CMD_ADD, 32'd0, 8'd0);
        push(CMD_ADD, 32'd0, 8'd0);
        push(CMD_READ, 32'd0, 8'd0);
        push(CMD_READ, 32'd0, 8'd128);
        push(CMD_READ, 32'd0, 8'd255);
        push(2'd3, 32'hFFFF_FFFF, 8'hFF);
        push(CMD_CLEAR, 32'd0, 8'd0);
        push(CMD_READ, 32'd0, 8'd0);
        for (int i = 0; i < 6; i++) push(CMD_ADD, 32'd7, 8'd0);
        push(CMD_READ, 32'd0, 8'd7);
        drain();
        random_phase(60);
        drain();

        write_reg(REG_RANGE_LOW, 32'd0);
        write_reg(REG_RANGE_HIGH, 32'hFFFF_FFFF);
        no_gaps = 1;
        random_phase(80);
        drain();
        no_gaps = 0;

        write_reg(REG_RANGE_LOW, 32'h8000_0000);
        write_reg(REG_RANGE_HIGH, 32'h8000_03FF);
        write_reg(REG_BUCKETS, 32'd37);
        random_phase(80);
        drain();

        // equal edges, then inverted edges: all to the first bucket
        write_reg(REG_RANGE_HIGH, 32'h8000_0000);
        random_phase(40);
        drain();
        write_reg(REG_RANGE_LOW, 32'hFFFF_FFFF);
        write_reg(REG_RANGE_HIGH, 32'd50);
        random_phase(40);
        drain();

        write_reg(REG_RANGE_LOW, 32'd1000);
        write_reg(REG_RANGE_HIGH, 32'd1100);
        write_reg(REG_BUCKETS, 32'd0);
        random_phase(50);
        drain();
        write_reg(REG_BUCKETS, 32'd1);
        random_phase(50);
        drain();
        write_reg(REG_BUCKETS, 32'h1FF);
        random_phase(80);
        drain();
        write_reg(REG_BUCKETS, 32'd256);
        write_reg(REG_RANGE_LOW, 32'd0);
        write_reg(REG_RANGE_HIGH, 32'd20);
        random_phase(110);
        drain();

        $display("sent %0d command beats over nine register settings, %0d reads checked",
                 beats_sent, reads_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/rslh_pkg.sv
rtl/rslh_div.sv
rtl/rslh_log.sv
rtl/range_scaled_log_histogram_top.sv
tb/tb_range_scaled_log_histogram_top.sv
